>>> rtl/core/iest_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker package
// Shared item types, event codes and register indexes of the tracker.
// ----------------------------------------------------------------------------
package iest_pkg;

	typedef struct packed {
		logic               cmd;
		logic [4:0]         ev_type;
		logic [9:0]         ev_code;
		logic signed [31:0] ev_value;
	} item_t;

	typedef struct packed {
		logic [9:0]         buttons;
		logic [15:0]        pointer_x;
		logic [15:0]        pointer_y;
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
		logic signed [15:0] direction_x;
		logic signed [15:0] direction_y;
		logic [31:0]        frame_number;
	} snap_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} key_hit_t;

	// Commands.
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	// Event classes.
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_REL = 5'd2;
	localparam logic [4:0] EV_ABS = 5'd3;

	// Axis codes.
	localparam logic [9:0] REL_X     = 10'd0;
	localparam logic [9:0] REL_Y     = 10'd1;
	localparam logic [9:0] ABS_X     = 10'd0;
	localparam logic [9:0] ABS_Y     = 10'd1;
	localparam logic [9:0] ABS_PAD_X = 10'd3;
	localparam logic [9:0] ABS_PAD_Y = 10'd4;

	// Key codes.
	localparam logic [9:0] KEY_ARROW_L  = 10'd105;
	localparam logic [9:0] KEY_ARROW_R  = 10'd106;
	localparam logic [9:0] KEY_UP       = 10'd103;
	localparam logic [9:0] KEY_ARROW_DN = 10'd108;
	localparam logic [9:0] KEY_BAR      = 10'd57;
	localparam logic [9:0] KEY_RETURN   = 10'd28;
	localparam logic [9:0] KEY_O        = 10'd111;
	localparam logic [9:0] KEY_BKSP     = 10'd14;
	localparam logic [9:0] BTN_MOUSE_L  = 10'd272;
	localparam logic [9:0] BTN_MOUSE_R  = 10'd273;
	localparam logic [9:0] BTN_SOUTH    = 10'd304;
	localparam logic [9:0] BTN_PAD_ST   = 10'd315;
	localparam logic [9:0] BTN_EAST     = 10'd305;
	localparam logic [9:0] BTN_PAD_SEL  = 10'd314;

	// Button bit positions.
	localparam logic [3:0] BIT_LEFT    = 4'd0;
	localparam logic [3:0] BIT_RIGHT   = 4'd1;
	localparam logic [3:0] BIT_UP      = 4'd2;
	localparam logic [3:0] BIT_DOWN    = 4'd3;
	localparam logic [3:0] BIT_BUTTON1 = 4'd4;
	localparam logic [3:0] BIT_BUTTON2 = 4'd5;
	localparam logic [3:0] BIT_MOUSE_L = 4'd6;
	localparam logic [3:0] BIT_MOUSE_R = 4'd7;
	localparam logic [3:0] BIT_PAD_A   = 4'd8;
	localparam logic [3:0] BIT_PAD_B   = 4'd9;

	// Configuration registers.
	localparam int unsigned CFG_IDX_W   = 2;
	localparam logic [1:0]  CFG_WIDTH   = 2'd0;
	localparam logic [1:0]  CFG_HEIGHT  = 2'd1;
	localparam logic [15:0] WIDTH_RST   = 16'd640;
	localparam logic [15:0] HEIGHT_RST  = 16'd480;

	localparam logic signed [17:0] AXIS_FULL = 18'sd32767;
	localparam logic signed [17:0] AXIS_NEG  = -18'sd32767;

	function automatic key_hit_t key_bit(input logic [9:0] code);
		key_hit_t r;
		r.hit = 1'b1;
		r.idx = BIT_LEFT;
		case (code)
			KEY_ARROW_L:  r.idx = BIT_LEFT;
			KEY_ARROW_R:  r.idx = BIT_RIGHT;
			KEY_UP:       r.idx = BIT_UP;
			KEY_ARROW_DN: r.idx = BIT_DOWN;
			KEY_BAR:      r.idx = BIT_BUTTON1;
			KEY_RETURN:   r.idx = BIT_BUTTON1;
			KEY_O:        r.idx = BIT_BUTTON2;
			KEY_BKSP:     r.idx = BIT_BUTTON2;
			BTN_MOUSE_L:  r.idx = BIT_MOUSE_L;
			BTN_MOUSE_R:  r.idx = BIT_MOUSE_R;
			BTN_SOUTH:    r.idx = BIT_PAD_A;
			BTN_PAD_ST:   r.idx = BIT_PAD_A;
			BTN_EAST:     r.idx = BIT_PAD_B;
			BTN_PAD_SEL:  r.idx = BIT_PAD_B;
			default:      r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/iest_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker channel interfaces
// Valid/ready channels for event items and for snapshot items.
// ----------------------------------------------------------------------------
interface iest_in_if;
	logic          valid;
	logic          ready;
	iest_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iest_out_if;
	logic          valid;
	logic          ready;
	iest_pkg::snap_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/iest_abs_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Absolute position scaler
// Maps a 0..65535 position onto 0..size as value * size / 65535, truncated.
// ----------------------------------------------------------------------------
module iest_abs_scale (
	input  logic [15:0] value,
	input  logic [15:0] size,
	output logic [15:0] scaled
);

	logic [31:0] prod;
	logic [32:0] sum;

	// For a product below 2^32, floor(p / 65535) equals (p + (p >> 16) + 1) >> 16.
	assign prod   = {16'd0, value} * {16'd0, size};
	assign sum    = {1'b0, prod} + {17'd0, prod[31:16]} + 33'd1;
	assign scaled = sum[31:16];

endmodule

>>> rtl/core/iest_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker state
// Holds buttons, pointer, pad axes and frame count; updates them per item.
// ----------------------------------------------------------------------------
module iest_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  iest_pkg::item_t item,
	input  logic [15:0]     size_w,
	input  logic [15:0]     size_h,
	output iest_pkg::snap_t snap
);

	logic [9:0]         buttons_q;
	logic [15:0]        pos_x_q;
	logic [15:0]        pos_y_q;
	logic signed [15:0] axis_x_q;
	logic signed [15:0] axis_y_q;
	logic [31:0]        frame_q;

	logic [9:0]         buttons_d;
	logic [15:0]        pos_x_d;
	logic [15:0]        pos_y_d;
	logic signed [15:0] axis_x_d;
	logic signed [15:0] axis_y_d;

	iest_pkg::key_hit_t key;
	logic               is_y;
	logic [15:0]        pos_sel;
	logic [15:0]        size_sel;
	logic signed [33:0] rel_sum;
	logic [15:0]        rel_pos;
	logic [15:0]        abs_in;
	logic [15:0]        abs_pos;
	logic signed [15:0] pad_val;

	assign key      = iest_pkg::key_bit(item.ev_code);
	assign is_y     = (item.ev_code == iest_pkg::REL_Y);
	assign pos_sel  = is_y ? pos_y_q : pos_x_q;
	assign size_sel = is_y ? size_h : size_w;

	always_comb begin
		rel_sum = $signed({18'd0, pos_sel}) + $signed({{2{item.ev_value[31]}}, item.ev_value});
		if (rel_sum < 0) begin
			rel_pos = 16'd0;
		end else if (rel_sum > $signed({18'd0, size_sel})) begin
			rel_pos = size_sel;
		end else begin
			rel_pos = rel_sum[15:0];
		end
	end

	always_comb begin
		if (item.ev_value < 0) begin
			abs_in = 16'd0;
		end else if (item.ev_value > 32'sd65535) begin
			abs_in = 16'hFFFF;
		end else begin
			abs_in = item.ev_value[15:0];
		end
		if (item.ev_value > 32'sd32767) begin
			pad_val = 16'sd32767;
		end else if (item.ev_value < -32'sd32767) begin
			pad_val = -16'sd32767;
		end else begin
			pad_val = item.ev_value[15:0];
		end
	end

	iest_abs_scale u_abs_scale (
		.value  (abs_in),
		.size   (size_sel),
		.scaled (abs_pos)
	);

	always_comb begin
		buttons_d = buttons_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		axis_x_d  = axis_x_q;
		axis_y_d  = axis_y_q;
		if (item.cmd == iest_pkg::CMD_EVENT) begin
			case (item.ev_type)
				iest_pkg::EV_KEY: begin
					if (key.hit) begin
						buttons_d[key.idx] = (item.ev_value != 32'sd0);
					end
				end
				iest_pkg::EV_REL: begin
					if (item.ev_code == iest_pkg::REL_X) begin
						pos_x_d = rel_pos;
					end else if (item.ev_code == iest_pkg::REL_Y) begin
						pos_y_d = rel_pos;
					end
				end
				iest_pkg::EV_ABS: begin
					case (item.ev_code)
						iest_pkg::ABS_X:     pos_x_d  = abs_pos;
						iest_pkg::ABS_Y:     pos_y_d  = abs_pos;
						iest_pkg::ABS_PAD_X: axis_x_d = pad_val;
						iest_pkg::ABS_PAD_Y: axis_y_d = pad_val;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Key term plus pad axis, each in 1/32767 units, saturated.
	function automatic logic signed [15:0] dir_axis(
		input logic neg,
		input logic pos,
		input logic signed [15:0] axis
	);
		logic signed [17:0] d;
		d = {{2{axis[15]}}, axis};
		if (neg) begin
			d = d + iest_pkg::AXIS_NEG;
		end
		if (pos) begin
			d = d + iest_pkg::AXIS_FULL;
		end
		if (d > iest_pkg::AXIS_FULL) begin
			d = iest_pkg::AXIS_FULL;
		end else if (d < iest_pkg::AXIS_NEG) begin
			d = iest_pkg::AXIS_NEG;
		end
		return d[15:0];
	endfunction

	always_comb begin
		snap.buttons      = buttons_q;
		snap.pointer_x    = pos_x_q;
		snap.pointer_y    = pos_y_q;
		snap.stick_x      = axis_x_q;
		snap.stick_y      = axis_y_q;
		snap.direction_x  = dir_axis(buttons_q[iest_pkg::BIT_LEFT],
			buttons_q[iest_pkg::BIT_RIGHT], axis_x_q);
		snap.direction_y  = dir_axis(buttons_q[iest_pkg::BIT_UP],
			buttons_q[iest_pkg::BIT_DOWN], axis_y_q);
		snap.frame_number = frame_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_q <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			axis_x_q  <= '0;
			axis_y_q  <= '0;
			frame_q   <= '0;
		end else if (adv) begin
			buttons_q <= buttons_d;
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			axis_x_q  <= axis_x_d;
			axis_y_q  <= axis_y_d;
			if (item.cmd == iest_pkg::CMD_FRAME) begin
				frame_q <= frame_q + 32'd1;
			end
		end
	end

endmodule

>>> rtl/core/input_event_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker
// Applies input events to held button, pointer and pad state and emits a
// snapshot with the direction vector on each end-of-frame item.
// ----------------------------------------------------------------------------
//   channel | dir | handshake   | payload
//   ev      | in  | valid/ready | cmd, ev_type, ev_code, ev_value
//   snap    | out | valid/ready | buttons, pointer, stick, direction, frame
//   cfg     | in  | cfg_we      | cfg_idx selects width (0) or height (1)
//
// Each item is registered, then applied to the state as it leaves the input
// register; one item per cycle is sustained unless a frame item stalls. A
// single output register takes the snapshot as a frame item is applied and
// holds it while it waits; events keep flowing behind it, and a second frame
// item waits in the input register, holding the input off, until it is taken.
// Reset clears all state and loads the default screen size of 640 by 480.
// ----------------------------------------------------------------------------
module input_event_state_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	iest_in_if.sink                       ev,
	iest_out_if.source                    snap,
	input  logic                          cfg_we,
	input  logic [iest_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_wdata
);

	logic [15:0]     width_q;
	logic [15:0]     height_q;
	iest_pkg::item_t item_s1;
	logic            valid_s1;
	iest_pkg::snap_t snap_q;
	logic            snap_valid_q;
	iest_pkg::snap_t snap_next;
	logic            out_free;
	logic            adv;
	logic            is_frame;

	assign is_frame = (item_s1.cmd == iest_pkg::CMD_FRAME);
	assign out_free = !snap_valid_q || snap.ready;
	assign adv      = valid_s1 && (!is_frame || out_free);
	assign ev.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= iest_pkg::WIDTH_RST;
			height_q <= iest_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				iest_pkg::CFG_WIDTH:  width_q  <= cfg_wdata;
				iest_pkg::CFG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ev.valid && ev.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.valid && ev.ready) begin
			item_s1 <= ev.data;
		end
	end

	iest_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.size_w (width_q),
		.size_h (height_q),
		.snap   (snap_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
		end else if (adv && is_frame) begin
			snap_valid_q <= 1'b1;
		end else if (snap.ready) begin
			snap_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_frame) begin
			snap_q <= snap_next;
		end
	end

	assign snap.valid = snap_valid_q;
	assign snap.data  = snap_q;

endmodule

>>> rtl/core/iest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the snapshot channel of the tracker and checks it over time.
// ----------------------------------------------------------------------------
module iest_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            snap_valid,
	input logic            snap_ready,
	input iest_pkg::snap_t snap_data
);

	logic [31:0] last_q;
	logic        seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
		end else if (snap_valid && snap_ready) begin
			seen_q <= 1'b1;
			last_q <= snap_data.frame_number;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && !snap_ready |=> snap_valid && $stable(snap_data))
		else $error("snapshot changed while stalled");

	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && snap_ready && seen_q |-> snap_data.frame_number == last_q + 32'd1)
		else $error("frame number did not advance by one");

	a_first_frame: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && snap_ready && !seen_q |-> snap_data.frame_number == 32'd1)
		else $error("first frame after reset is not number one");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> snap_data.direction_x != 16'h8000 && snap_data.direction_y != 16'h8000
			&& snap_data.stick_x != 16'h8000 && snap_data.stick_y != 16'h8000)
		else $error("axis value outside its saturated range");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !snap_valid)
		else $error("snapshot valid during reset");

endmodule

bind input_event_state_tracker iest_checker u_iest_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.snap_valid (snap.valid),
	.snap_ready (snap.ready),
	.snap_data  (snap.data)
);

>>> test/tb_input_event_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker testbench
// Sends key, relative, absolute and frame items with random gaps while the
// snapshot side stalls at random. A cycle-free model of the held state
// predicts every snapshot, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb_input_event_state_tracker;
	import iest_pkg::*;

	localparam int SETTLE_CYCLES    = 6;
	localparam int STALL_LIMIT      = 3000;
	localparam int RANDOM_PER_PHASE = 190;
	localparam int RANDOM_PHASES    = 6;
	localparam int MAX_REPORTS      = 40;

	localparam longint PAD_FULL = 32767;
	localparam longint ABS_SPAN = 65535;

	// Indexes that decode to no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// Other codes of the usual numbering that the block must not react to.
	localparam logic [9:0] REL_SCROLL = 10'd8;
	localparam logic [9:0] ABS_Z      = 10'd2;
	localparam logic [9:0] ABS_RZ     = 10'd5;
	localparam logic [9:0] CODE_TOP   = 10'd767;
	localparam logic [4:0] EV_SYN     = 5'd0;
	localparam logic [4:0] EV_TOP     = 5'd31;

	localparam logic [9:0] KEY_CODES [14] = '{
		KEY_ARROW_L, KEY_ARROW_R, KEY_UP, KEY_ARROW_DN, KEY_BAR, KEY_RETURN, KEY_O,
		KEY_BKSP, BTN_MOUSE_L, BTN_MOUSE_R, BTN_SOUTH, BTN_PAD_ST, BTN_EAST, BTN_PAD_SEL
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [15:0]          cfg_wdata;

	iest_in_if  ev_ch ();
	iest_out_if snap_ch ();

	input_event_state_tracker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (ev_ch),
		.snap      (snap_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Expected input state, kept in step with every accepted item.
	logic [9:0]         held_buttons = '0;
	logic [15:0]        held_px      = '0;
	logic [15:0]        held_py      = '0;
	logic signed [15:0] held_pad_x   = '0;
	logic signed [15:0] held_pad_y   = '0;
	logic [31:0]        frames_seen  = '0;
	logic [15:0]        scr_w        = WIDTH_RST;
	logic [15:0]        scr_h        = HEIGHT_RST;

	snap_t snapshots_due[$];

	bit calm          = 1'b0;
	int errors        = 0;
	int events_taken  = 0;
	int snaps_checked = 0;
	int settings_used = 1;
	int idle_count    = 0;
	int stall_left    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int key_slot(logic [9:0] code);
		case (code)
			KEY_ARROW_L:             return BIT_LEFT;
			KEY_ARROW_R:             return BIT_RIGHT;
			KEY_UP:                  return BIT_UP;
			KEY_ARROW_DN:            return BIT_DOWN;
			KEY_BAR, KEY_RETURN:     return BIT_BUTTON1;
			KEY_O, KEY_BKSP:         return BIT_BUTTON2;
			BTN_MOUSE_L:             return BIT_MOUSE_L;
			BTN_MOUSE_R:             return BIT_MOUSE_R;
			BTN_SOUTH, BTN_PAD_ST:   return BIT_PAD_A;
			BTN_EAST, BTN_PAD_SEL:   return BIT_PAD_B;
			default:                 return -1;
		endcase
	endfunction

	// Key term of one axis plus the pad axis, held within full scale.
	function automatic logic signed [15:0] steer(logic neg, logic pos,
			logic signed [15:0] pad);
		longint d;
		d = longint'(pad);
		if (neg)
			d -= PAD_FULL;
		if (pos)
			d += PAD_FULL;
		return 16'(clamp(d, -PAD_FULL, PAD_FULL));
	endfunction

	task automatic track_item(item_t it);
		int     slot;
		longint v;
		snap_t  s;
		v = longint'($signed(it.ev_value));
		if (it.cmd == CMD_FRAME) begin
			frames_seen = frames_seen + 32'd1;
			s.buttons      = held_buttons;
			s.pointer_x    = held_px;
			s.pointer_y    = held_py;
			s.stick_x      = held_pad_x;
			s.stick_y      = held_pad_y;
			s.direction_x  = steer(held_buttons[BIT_LEFT], held_buttons[BIT_RIGHT], held_pad_x);
			s.direction_y  = steer(held_buttons[BIT_UP], held_buttons[BIT_DOWN], held_pad_y);
			s.frame_number = frames_seen;
			snapshots_due.push_back(s);
		end else begin
			case (it.ev_type)
				EV_KEY: begin
					slot = key_slot(it.ev_code);
					if (slot >= 0)
						held_buttons[slot[3:0]] = (it.ev_value != 0);
				end
				EV_REL: begin
					if (it.ev_code == REL_X)
						held_px = 16'(clamp(longint'(held_px) + v, 0, longint'(scr_w)));
					else if (it.ev_code == REL_Y)
						held_py = 16'(clamp(longint'(held_py) + v, 0, longint'(scr_h)));
				end
				EV_ABS: begin
					if (it.ev_code == ABS_X)
						held_px = 16'(clamp(v, 0, ABS_SPAN) * longint'(scr_w) / ABS_SPAN);
					else if (it.ev_code == ABS_Y)
						held_py = 16'(clamp(v, 0, ABS_SPAN) * longint'(scr_h) / ABS_SPAN);
					else if (it.ev_code == ABS_PAD_X)
						held_pad_x = 16'(clamp(v, -PAD_FULL, PAD_FULL));
					else if (it.ev_code == ABS_PAD_Y)
						held_pad_y = 16'(clamp(v, -PAD_FULL, PAD_FULL));
				end
				default: ;
			endcase
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: snapshot %0d, %s: got %h, expected %h",
				$realtime, snaps_checked, what, got, want);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	always @(posedge clk) begin : monitor
		snap_t want;
		if (arst_n) begin
			if (ev_ch.valid && ev_ch.ready) begin
				events_taken++;
				track_item(ev_ch.data);
			end
			if (snap_ch.valid && snap_ch.ready) begin
				if (snapshots_due.size() == 0) begin
					report_mismatch("unexpected snapshot", snap_ch.data.frame_number, '0);
				end else begin
					want = snapshots_due.pop_front();
					check_field("buttons", 32'(snap_ch.data.buttons), 32'(want.buttons));
					check_field("pointer_x", 32'(snap_ch.data.pointer_x),
						32'(want.pointer_x));
					check_field("pointer_y", 32'(snap_ch.data.pointer_y),
						32'(want.pointer_y));
					check_field("stick_x", 32'(snap_ch.data.stick_x), 32'(want.stick_x));
					check_field("stick_y", 32'(snap_ch.data.stick_y), 32'(want.stick_y));
					check_field("direction_x", 32'(snap_ch.data.direction_x),
						32'(want.direction_x));
					check_field("direction_y", 32'(snap_ch.data.direction_y),
						32'(want.direction_y));
					check_field("frame_number", snap_ch.data.frame_number,
						want.frame_number);
				end
				snaps_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (ev_ch.valid && ev_ch.ready) || (snap_ch.valid && snap_ch.ready)) begin
			idle_count <= 0;
		end else if (idle_count >= STALL_LIMIT) begin
			$display("Timeout: nothing moved on either channel for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	// Mostly no gap, some short ones and now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (calm) begin
			snap_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			snap_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 20) begin
			stall_left    <= pick_gap();
			snap_ch.ready <= 1'b0;
		end else begin
			snap_ch.ready <= 1'b1;
		end
	end

	function automatic item_t ev_item(logic [4:0] kind, logic [9:0] code, logic [31:0] value);
		item_t it;
		it.cmd      = CMD_EVENT;
		it.ev_type  = kind;
		it.ev_code  = code;
		it.ev_value = value;
		return it;
	endfunction

	// The event fields of a frame item carry junk; the block must ignore them.
	function automatic item_t frame_item();
		item_t it;
		it.cmd      = CMD_FRAME;
		it.ev_type  = 5'($urandom_range(0, 31));
		it.ev_code  = 10'($urandom_range(0, 1023));
		it.ev_value = $urandom;
		return it;
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			ev_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ev_ch.valid <= 1'b1;
		ev_ch.data  <= it;
		do @(posedge clk); while (!ev_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		ev_ch.valid <= 1'b0;
		while (snapshots_due.size() != 0)
			@(negedge clk);
	endtask

	// An event item leaves no result behind, so give the last one time to
	// land before the screen size changes under it.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		if (idx == CFG_WIDTH)
			scr_w = value;
		else if (idx == CFG_HEIGHT)
			scr_h = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t random_item(output bit useful);
		int          r;
		int          pick;
		logic [4:0]  kind;
		logic [9:0]  code;
		logic [31:0] value;
		r      = $urandom_range(0, 99);
		pick   = $urandom_range(0, 99);
		useful = 1'b1;
		if (r < 15)
			return frame_item();
		if (r < 45) begin
			kind = EV_KEY;
			code = (pick < 90) ? KEY_CODES[pick % 14] : 10'($urandom_range(0, 1023));
			pick = $urandom_range(0, 99);
			value = (pick < 45) ? 32'd1 : (pick < 85) ? 32'd0 : $urandom;
		end else if (r < 65) begin
			kind = EV_REL;
			code = (pick < 92) ? ((pick % 2 == 0) ? REL_X : REL_Y) : 10'($urandom_range(0, 1023));
			pick = $urandom_range(0, 99);
			if (pick < 80)
				value = int'($urandom_range(0, 600)) - 300;
			else if (pick < 95)
				value = int'($urandom_range(0, 140000)) - 70000;
			else
				value = $urandom;
		end else if (r < 92) begin
			kind = EV_ABS;
			if (pick < 92)
				code = (pick % 4 == 0) ? ABS_X : (pick % 4 == 1) ? ABS_Y :
					(pick % 4 == 2) ? ABS_PAD_X : ABS_PAD_Y;
			else
				code = 10'($urandom_range(0, 1023));
			pick = $urandom_range(0, 99);
			if (code == ABS_X || code == ABS_Y)
				value = (pick < 70) ? 32'($urandom_range(0, 65535)) :
					(pick < 85) ? int'($urandom_range(0, 200000)) - 100000 : $urandom;
			else
				value = (pick < 75) ? int'($urandom_range(0, 65534)) - 32767 :
					(pick < 90) ? int'($urandom_range(0, 100000)) - 50000 : $urandom;
		end else begin
			useful = 1'b0;
			kind   = 5'($urandom_range(0, 31));
			code   = 10'($urandom_range(0, 1023));
			value  = $urandom;
		end
		return ev_item(kind, code, value);
	endfunction

	task automatic test_keys_and_direction();
		logic [31:0] press;
		send_item(frame_item());
		foreach (KEY_CODES[i]) begin
			press = (i % 3 == 0) ? 32'd1 : (i % 3 == 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
			send_item(ev_item(EV_KEY, KEY_CODES[i], press));
		end
		// Opposite keys cancel, so the pad alone sets the direction.
		send_item(ev_item(EV_ABS, ABS_PAD_X, 32'sd40000));
		send_item(frame_item());
		send_item(ev_item(EV_KEY, KEY_ARROW_R, 32'd0));
		send_item(ev_item(EV_ABS, ABS_PAD_X, 32'h8000_0000));
		send_item(ev_item(EV_ABS, ABS_PAD_Y, 32'h7FFF_FFFF));
		send_item(frame_item());
	endtask

	task automatic test_pointer();
		send_item(ev_item(EV_REL, REL_X, 32'h7FFF_FFFF));
		send_item(ev_item(EV_REL, REL_Y, 32'h8000_0000));
		send_item(ev_item(EV_ABS, ABS_Y, 32'd65535));
		send_item(ev_item(EV_ABS, ABS_X, 32'd32768));
		send_item(frame_item());
		send_item(ev_item(EV_ABS, ABS_X, -32'sd5));
		send_item(ev_item(EV_ABS, ABS_Y, 32'd70000));
		send_item(frame_item());
	endtask

	task automatic test_ignored_events();
		send_item(ev_item(EV_SYN, KEY_ARROW_R, 32'd1));
		send_item(ev_item(EV_TOP, KEY_ARROW_R, 32'd1));
		send_item(ev_item(EV_KEY, CODE_TOP, 32'd1));
		send_item(ev_item(EV_REL, REL_SCROLL, 32'd1));
		send_item(ev_item(EV_ABS, ABS_Z, 32'd100));
		send_item(ev_item(EV_ABS, ABS_RZ, 32'd100));
		send_item(frame_item());
	endtask

	task automatic test_screen_sizes();
		write_reg(CFG_WIDTH, 16'hFFFF);
		write_reg(CFG_HEIGHT, 16'd1);
		send_item(ev_item(EV_REL, REL_X, 32'h7FFF_FFFF));
		send_item(ev_item(EV_ABS, ABS_Y, 32'd65535));
		send_item(frame_item());
		// A narrower screen leaves the held position alone until x moves again.
		write_reg(CFG_WIDTH, 16'd10);
		send_item(frame_item());
		send_item(ev_item(EV_REL, REL_X, 32'd0));
		send_item(frame_item());
		write_reg(CFG_WIDTH, 16'd0);
		write_reg(CFG_HEIGHT, 16'd0);
		send_item(ev_item(EV_ABS, ABS_X, 32'd65535));
		send_item(ev_item(EV_REL, REL_Y, 32'd5));
		send_item(frame_item());
		write_reg(CFG_SPARE_2, 16'hFFFF);
		write_reg(CFG_SPARE_3, 16'hFFFF);
		send_item(ev_item(EV_ABS, ABS_X, 32'd65535));
		send_item(frame_item());
		write_reg(CFG_WIDTH, WIDTH_RST);
		write_reg(CFG_HEIGHT, HEIGHT_RST);
		settings_used += 4;
	endtask

	task automatic test_random_traffic();
		logic [15:0] w;
		logic [15:0] h;
		int          counted;
		bit          useful;
		bit          paused;
		item_t       it;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin w = WIDTH_RST; h = HEIGHT_RST; end
				1: begin w = 16'd1; h = 16'd1; end
				2: begin w = 16'hFFFF; h = 16'hFFFF; end
				3: begin w = 16'($urandom_range(1, 64)); h = 16'($urandom_range(1, 64)); end
				default: begin
					w = 16'($urandom_range(1, 65535));
					h = 16'($urandom_range(1, 65535));
				end
			endcase
			write_reg(CFG_WIDTH, w);
			write_reg(CFG_HEIGHT, h);
			settings_used++;
			// One phase runs back to back with the snapshot side always ready.
			calm    = (phase == 2);
			counted = 0;
			paused  = 1'b0;
			while (counted < RANDOM_PER_PHASE) begin
				if (!paused && counted == RANDOM_PER_PHASE / 2) begin
					drain();
					paused = 1'b1;
				end
				it = random_item(useful);
				send_item(it);
				if (useful)
					counted++;
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = CFG_WIDTH;
		cfg_wdata     = '0;
		ev_ch.valid   = 1'b0;
		ev_ch.data    = '0;
		snap_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_keys_and_direction();
		test_pointer();
		test_ignored_events();
		test_screen_sizes();
		test_random_traffic();

		drain();
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		$display("Applied %0d items and checked %0d snapshots over %0d screen settings,",
			events_taken, snaps_checked, settings_used);
		$display("with random gaps on both channels and a zero-size and shrunk screen.");
		if (errors == 0 && snapshots_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
